// ===== hw/rtl/alba_pkg.sv =====
// ----------------------------------------------------------------------------
// alba_pkg
// shared types, register codes and constants of the audio level, beat and
// gain stage
// ----------------------------------------------------------------------------
package alba_pkg;

  localparam int unsigned SampleBitsDef = 12;
  localparam int unsigned FracBitsDef   = 8;

  localparam int unsigned TimeBits    = 32;
  localparam int unsigned TargetBits  = 8;
  localparam int unsigned ScaledBits  = 8;
  localparam int unsigned SquelchBits = 8;
  localparam int unsigned MarginBits  = 8;
  localparam int unsigned HoldoffBits = 16;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned AvgShift    = 5;

  localparam logic [SquelchBits-1:0] SquelchRst = 8'd7;
  localparam logic [MarginBits-1:0]  MarginRst  = 8'd11;
  localparam logic [TargetBits-1:0]  TargetRst  = 8'd60;
  localparam logic [HoldoffBits-1:0] HoldoffRst = 16'd50;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_SQUELCH = 2'd0,
    REG_MARGIN  = 2'd1,
    REG_TARGET  = 2'd2,
    REG_HOLDOFF = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DC,
    ST_LVL,
    ST_AVG,
    ST_PEAK,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic step_dc;
    logic step_lvl;
    logic step_avg;
    logic div_init;
    logic div_step;
    logic mul;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/alba_ctrl.sv =====
// ----------------------------------------------------------------------------
// alba_ctrl
// sequencer that steps one sample through the datapath and owns the
// handshakes of both streams
// ----------------------------------------------------------------------------
module alba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output alba_pkg::dp_cmd_t    cmd_o,
  input  alba_pkg::dp_status_t status_i
);
  import alba_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DC;
      end
      ST_DC:   state_d = ST_LVL;
      ST_LVL:  state_d = ST_AVG;
      ST_AVG:  state_d = ST_PEAK;
      ST_PEAK: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_DC:   cmd_o.step_dc  = 1'b1;
      ST_LVL:  cmd_o.step_lvl = 1'b1;
      ST_AVG:  cmd_o.step_avg = 1'b1;
      ST_PEAK: cmd_o.div_init = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_MUL:  cmd_o.mul      = 1'b1;
      ST_DONE: cmd_o.out_load = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/alba_dp.sv =====
// ----------------------------------------------------------------------------
// alba_dp
// datapath: settings, running averages, squelch, peak test, serial divider
// for the gain factor and the output register
// ----------------------------------------------------------------------------
module alba_dp #(
  parameter  int unsigned SAMPLE_BITS = alba_pkg::SampleBitsDef,
  parameter  int unsigned FRAC_BITS   = alba_pkg::FracBitsDef,
  localparam int unsigned InBits  = ((SAMPLE_BITS + alba_pkg::TimeBits + 7) / 8) * 8,
  localparam int unsigned OutBits = ((2 * SAMPLE_BITS + alba_pkg::ScaledBits + 1 + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [alba_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [alba_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic [InBits-1:0]                in_data_i,
  output logic [OutBits-1:0]               out_data_o,
  input  alba_pkg::dp_cmd_t                cmd_i,
  output alba_pkg::dp_status_t             status_o
);
  import alba_pkg::*;

  localparam int unsigned AW = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned WW = AW + AvgShift + 1;
  localparam int unsigned NW = TargetBits + FRAC_BITS;
  localparam int unsigned RW = AW + 1;
  localparam int unsigned CW = $clog2(NW);
  localparam int unsigned PW = SAMPLE_BITS + TargetBits;

  function automatic logic [AW-1:0] avg31(input logic [AW-1:0] old,
                                          input logic [SAMPLE_BITS-1:0] val);
    logic [WW-1:0] s;
    s = WW'({old, {AvgShift{1'b0}}}) - WW'(old) + WW'({val, {FRAC_BITS{1'b0}}});
    return s[AW+AvgShift-1:AvgShift];
  endfunction

  // settings
  logic [SquelchBits-1:0] squelch_q;
  logic [MarginBits-1:0]  margin_q;
  logic [TargetBits-1:0]  target_q;
  logic [HoldoffBits-1:0] holdoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      squelch_q <= SquelchRst;
      margin_q  <= MarginRst;
      target_q  <= TargetRst;
      holdoff_q <= HoldoffRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SQUELCH: squelch_q <= cfg_data_i[SquelchBits-1:0];
        REG_MARGIN:  margin_q  <= cfg_data_i[MarginBits-1:0];
        REG_TARGET:  target_q  <= cfg_data_i[TargetBits-1:0];
        REG_HOLDOFF: holdoff_q <= cfg_data_i[HoldoffBits-1:0];
        default: ;
      endcase
    end
  end

  // item state
  logic [SAMPLE_BITS-1:0] mic_q;
  logic [TimeBits-1:0]    time_q;
  logic [SAMPLE_BITS-1:0] dev_q;
  logic [AW-1:0]          dc_q;
  logic [SAMPLE_BITS-1:0] sm_q;
  logic [AW-1:0]          slow_q;
  logic [TimeBits-1:0]    last_q;
  logic                   peak_q;
  logic [ScaledBits-1:0]  scaled_q;
  logic [RW-1:0]          rem_q;
  logic [NW-1:0]          quo_q;
  logic [CW-1:0]          cnt_q;
  logic [OutBits-1:0]     out_q;

  logic [AW-1:0]          dc_new, micf, absdiff;
  logic [SAMPLE_BITS:0]   lvl_sum;
  logic [SAMPLE_BITS-1:0] sm_new;
  logic [AW:0]            lvl_fx, thr;
  logic                   peak_new;
  logic [RW-1:0]          trial, den, diff;
  logic                   ge;
  logic [TargetBits-1:0]  mult;
  logic [PW-1:0]          prod;
  logic [ScaledBits-1:0]  scaled_new;

  always_comb begin
    dc_new  = avg31(dc_q, mic_q);
    micf    = {mic_q, {FRAC_BITS{1'b0}}};
    absdiff = (micf >= dc_new) ? (micf - dc_new) : (dc_new - micf);

    lvl_sum = {1'b0, sm_q} + {1'b0, dev_q};
    sm_new  = (dev_q <= SAMPLE_BITS'(squelch_q)) ? '0 : lvl_sum[SAMPLE_BITS:1];

    lvl_fx   = (AW+1)'({sm_q, {FRAC_BITS{1'b0}}});
    thr      = (AW+1)'(slow_q) + (AW+1)'({margin_q, {FRAC_BITS{1'b0}}});
    peak_new = (lvl_fx > thr) && ((time_q - last_q) > TimeBits'(holdoff_q));

    trial = {rem_q[RW-2:0], quo_q[NW-1]};
    den   = {1'b0, slow_q};
    ge    = trial >= den;
    diff  = trial - den;

    // average below one keeps the plain target as gain
    mult       = (slow_q[AW-1:FRAC_BITS] == '0) ? target_q : quo_q[TargetBits-1:0];
    prod       = PW'(sm_q) * PW'(mult);
    scaled_new = (|prod[PW-1:ScaledBits]) ? {ScaledBits{1'b1}} : prod[ScaledBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q   <= '0;
      sm_q   <= '0;
      slow_q <= '0;
      last_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.step_dc)  dc_q   <= dc_new;
      if (cmd_i.step_lvl) sm_q   <= sm_new;
      if (cmd_i.step_avg) slow_q <= avg31(slow_q, sm_q);
      if (cmd_i.div_init) begin
        cnt_q <= CW'(NW - 1);
        if (peak_new) last_q <= time_q;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mic_q  <= in_data_i[SAMPLE_BITS-1:0];
      time_q <= in_data_i[SAMPLE_BITS+TimeBits-1:SAMPLE_BITS];
    end
    if (cmd_i.step_dc) dev_q <= absdiff[AW-1:FRAC_BITS];
    if (cmd_i.div_init) begin
      peak_q <= peak_new;
      rem_q  <= '0;
      quo_q  <= {target_q, {FRAC_BITS{1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff : trial;
      quo_q <= {quo_q[NW-2:0], ge};
    end
    if (cmd_i.mul) scaled_q <= scaled_new;
    if (cmd_i.out_load) begin
      out_q <= OutBits'({peak_q, scaled_q, slow_q[AW-1:FRAC_BITS], sm_q});
    end
  end

  assign status_o.div_last = (cnt_q == '0);
  assign out_data_o        = out_q;

endmodule

// ===== hw/rtl/audio_level_beat_agc_top.sv =====
// ----------------------------------------------------------------------------
// audio_level_beat_agc_top
// microphone level follower with beat detection and automatic gain
// samples are taken one at a time: a new sample is accepted only once the
//   last one has reached the output register; the bit-serial gain divider
//   produces one quotient bit per cycle
// a finished result may wait in the output register while the next sample
//   is taken
// reset: asynchronous active low; averages, smoothed level and last peak
//   time clear to zero, settings return to their defaults
// ----------------------------------------------------------------------------
module audio_level_beat_agc_top #(
  parameter  int unsigned SAMPLE_BITS = alba_pkg::SampleBitsDef,
  parameter  int unsigned FRAC_BITS   = alba_pkg::FracBitsDef,
  localparam int unsigned InBits  = ((SAMPLE_BITS + alba_pkg::TimeBits + 7) / 8) * 8,
  localparam int unsigned OutBits = ((2 * SAMPLE_BITS + alba_pkg::ScaledBits + 1 + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [alba_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [alba_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // mic_sample, time_ms
  input  logic [InBits-1:0]                s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // level, average_level, scaled_level, peak
  output logic [OutBits-1:0]               m_axis_tdata_o
);
  import alba_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  alba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  alba_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

// ===== hw/rtl/alba_chk.sv =====
// ----------------------------------------------------------------------------
// alba_chk
// port-level checks of the audio level, beat and gain stage
// ----------------------------------------------------------------------------
module alba_chk #(
  parameter  int unsigned SAMPLE_BITS = alba_pkg::SampleBitsDef,
  parameter  int unsigned FRAC_BITS   = alba_pkg::FracBitsDef,
  localparam int unsigned OutBits = ((2 * SAMPLE_BITS + alba_pkg::ScaledBits + 1 + 7) / 8) * 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [OutBits-1:0] m_axis_tdata_o
);
  import alba_pkg::*;

  localparam int unsigned LvlLo  = 0;
  localparam int unsigned ScLo   = 2 * SAMPLE_BITS;
  localparam int unsigned PeakAt = 2 * SAMPLE_BITS + ScaledBits;

  logic [SAMPLE_BITS-1:0] out_level;
  logic [ScaledBits-1:0]  out_scaled;
  logic                   out_peak;
  logic                   in_xfer;

  assign out_level  = m_axis_tdata_o[LvlLo+SAMPLE_BITS-1:LvlLo];
  assign out_scaled = m_axis_tdata_o[ScLo+ScaledBits-1:ScLo];
  assign out_peak   = m_axis_tdata_o[PeakAt];
  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready_o)
    else $error("second sample taken while one is in work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a sample in work");

  a_peak_needs_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_peak |-> out_level != '0)
    else $error("peak reported on a silent level");

  a_silent_unscaled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_level == '0) |-> out_scaled == '0)
    else $error("nonzero scaled level from a zero level");

endmodule

bind audio_level_beat_agc_top alba_chk #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .FRAC_BITS   (FRAC_BITS)
) u_alba_chk (.*);

// ===== sim/audio_level_beat_agc_checker.sv =====
// ----------------------------------------------------------------------------
// audio_level_beat_agc_checker
// watches the setting writes and both stream channels of the level, beat and
// gain stage, predicts every result from the accepted samples and compares
// ----------------------------------------------------------------------------
module audio_level_beat_agc_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [alba_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [alba_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  // mic_sample, time_ms
  input  logic [47:0]                      s_tdata_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  // level, average_level, scaled_level, peak
  input  logic [39:0]                      m_tdata_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               results_o,
  output int                               peaks_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import alba_pkg::*;

  typedef struct packed {
    logic        peak;
    logic [7:0]  scaled;
    logic [11:0] avg;
    logic [11:0] level;
  } level_result_t;

  logic [SquelchBits-1:0] squelch;
  logic [MarginBits-1:0]  margin;
  logic [TargetBits-1:0]  target;
  logic [HoldoffBits-1:0] holdoff;

  logic [19:0] dc_acc;
  logic [11:0] level_acc;
  logic [19:0] slow_acc;
  logic [31:0] last_peak;

  level_result_t expected_levels_q[$];
  int            fails;
  int            n_results;
  int            n_peaks;

  function automatic logic [19:0] ema31(input logic [19:0] prev, input logic [11:0] val);
    logic [25:0] acc;
    acc = 26'(prev) * 26'd31 + {6'd0, val, 8'd0};
    return acc[24:5];
  endfunction

  function automatic level_result_t track_sample(input logic [11:0] mic,
                                                 input logic [31:0] now);
    logic [19:0]   mic_fx;
    logic [19:0]   abs_dev;
    logic [11:0]   dev;
    logic [12:0]   sum;
    logic [20:0]   thresh;
    logic [31:0]   since;
    logic [19:0]   gain;
    logic [31:0]   prod;
    level_result_t res;
    dc_acc  = ema31(dc_acc, mic);
    mic_fx  = {mic, 8'd0};
    abs_dev = (mic_fx >= dc_acc) ? mic_fx - dc_acc : dc_acc - mic_fx;
    dev     = abs_dev[19:8];
    if (dev <= {4'd0, squelch}) begin
      level_acc = '0;
    end else begin
      sum       = {1'b0, level_acc} + {1'b0, dev};
      level_acc = sum[12:1];
    end
    slow_acc = ema31(slow_acc, level_acc);
    thresh   = {1'b0, slow_acc} + {5'd0, margin, 8'd0};
    since    = now - last_peak;
    res.peak = ({1'b0, level_acc, 8'd0} > thresh) && (since > {16'd0, holdoff});
    if (res.peak) begin
      last_peak = now;
    end
    if (slow_acc < 20'd256) begin
      gain = {12'd0, target};
    end else begin
      gain = {4'd0, target, 8'd0} / slow_acc;
    end
    prod       = {20'd0, level_acc} * gain;
    res.scaled = (prod > 32'd255) ? 8'hFF : prod[7:0];
    res.level  = level_acc;
    res.avg    = slow_acc[19:8];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    level_result_t got;
    level_result_t want;
    if (!rst_ni) begin
      squelch   = SquelchRst;
      margin    = MarginRst;
      target    = TargetRst;
      holdoff   = HoldoffRst;
      dc_acc    = '0;
      level_acc = '0;
      slow_acc  = '0;
      last_peak = '0;
      expected_levels_q.delete();
      fails     = 0;
      n_results = 0;
      n_peaks   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SQUELCH: squelch = cfg_data_i[SquelchBits-1:0];
          REG_MARGIN:  margin  = cfg_data_i[MarginBits-1:0];
          REG_TARGET:  target  = cfg_data_i[TargetBits-1:0];
          REG_HOLDOFF: holdoff = cfg_data_i[HoldoffBits-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_levels_q.push_back(track_sample(s_tdata_i[11:0], s_tdata_i[43:12]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[32:0];
        n_results++;
        if (got.peak) n_peaks++;
        if (expected_levels_q.size() == 0) begin
          fails++;
          $display({"%0t: unexpected result, expected none, ",
                    "actual level %0d avg %0d scaled %0d peak %0d"},
                   $time, got.level, got.avg, got.scaled, got.peak);
        end else begin
          want = expected_levels_q.pop_front();
          if (got !== want) begin
            fails++;
            $display({"%0t: expected level %0d avg %0d scaled %0d peak %0d, ",
                      "actual level %0d avg %0d scaled %0d peak %0d"},
                     $time, want.level, want.avg, want.scaled, want.peak,
                     got.level, got.avg, got.scaled, got.peak);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_levels_q.size();
    results_o    <= n_results;
    peaks_o      <= n_peaks;
  end

endmodule

// ===== sim/tb_audio_level_beat_agc_top.sv =====
// ----------------------------------------------------------------------------
// tb_audio_level_beat_agc_top
// drives microphone samples with millisecond timestamps through the level,
// beat and gain stage under several settings and idle patterns; a checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_audio_level_beat_agc_top;

  timeunit 1ns;
  timeprecision 1ps;

  import alba_pkg::*;

  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 230;
  localparam int CycleLimit  = 600000;
  localparam int SettleCyc   = 30;
  localparam int HoldCyc     = 400;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx    = '0;
  logic [CfgDataBits-1:0] cfg_data   = '0;
  logic                   s_tvalid   = 1'b0;
  logic                   s_tready;
  logic [47:0]            s_tdata    = '0;
  logic                   m_tvalid;
  logic                   m_tready   = 1'b0;
  logic [39:0]            m_tdata;

  int fail_count;
  int pending;
  int results;
  int peaks;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic        hold_req  = 1'b0;
  logic        hold_done;
  int          hold_left;
  int          cycles    = 0;
  int          sent      = 0;
  int          dc_base   = 2048;
  int          burst_left = 0;
  logic [31:0] time_now  = '0;

  int unsigned d_mic[24] = '{0, 4095, 4095, 0, 4095, 0, 2048, 2048, 4095, 4095, 4095, 0,
                             1, 4094, 2048, 2049, 4095, 0, 4095, 0, 4095, 0, 3000, 100};
  logic [31:0] d_time[24] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd51, 32'd52, 32'd102,
                              32'd103, 32'd104, 32'd153, 32'd154, 32'd155,
                              32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0000_0010, 32'h0000_0020,
                              32'h0000_0040, 32'h0000_0041, 32'h0000_0073, 32'h0000_0074,
                              32'h8000_0000, 32'h8000_0001, 32'h8000_0033, 32'h8000_0034};

  audio_level_beat_agc_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  audio_level_beat_agc_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .peaks_o      (peaks)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver side: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCyc;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_sample(input logic [11:0] mic, input logic [31:0] stamp);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    s_tdata  <= {4'd0, stamp, mic};
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [7:0] sq, input logic [7:0] mg,
                                input logic [7:0] tg, input logic [15:0] ho);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SQUELCH;
    cfg_data <= {8'($urandom), sq};
    @(posedge clk_i);
    cfg_idx  <= REG_MARGIN;
    cfg_data <= {8'($urandom), mg};
    @(posedge clk_i);
    cfg_idx  <= REG_TARGET;
    cfg_data <= {8'($urandom), tg};
    @(posedge clk_i);
    cfg_idx  <= REG_HOLDOFF;
    cfg_data <= ho;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [7:0] pick8();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 60));
  endfunction

  task automatic next_sample(output logic [11:0] mic);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      if (r < 50) v = $urandom_range(0, 4095);
      else v = dc_base + $urandom_range(0, 3000) - 1500;
    end else if (r < 6) begin
      burst_left = $urandom_range(2, 10);
      v = $urandom_range(0, 4095);
    end else if (r < 9) begin
      v = $urandom_range(0, 1) ? 4095 : 0;
    end else if (r < 14) begin
      v = $urandom_range(0, 4095);
    end else begin
      v = dc_base + $urandom_range(0, 24) - 12;
    end
    if (r == 99) dc_base = $urandom_range(0, 4095);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    mic = 12'(v);
  endtask

  task automatic advance_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) time_now = time_now + $urandom_range(0, 15);
    else if (r < 97) time_now = time_now + $urandom_range(16, 400);
    else time_now = $urandom();
  endtask

  initial begin
    logic [11:0] mic;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: extremes, wrap of the timestamp, holdoff edges
    for (int i = 0; i < 24; i++) begin
      send_sample(12'(d_mic[i]), d_time[i]);
    end
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: write_settings(8'd0, 8'd0, 8'd0, 16'd0);
        1: write_settings(8'd255, 8'd255, 8'd255, 16'hFFFF);
        2: write_settings(8'd0, 8'd255, 8'd255, 16'd0);
        default: write_settings(pick8(), pick8(), 8'($urandom_range(0, 255)),
                                ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                            : 16'($urandom_range(0, 300)));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 66; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 66; end
        default: begin idle_pct = 8; stall_pct <= 8; end
      endcase
      if (p == 4) hold_req <= 1'b1;
      dc_base  = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 4095 : 0)
                                             : $urandom_range(0, 4095);
      time_now = (p == 5) ? 32'hFFFF_FE00 : $urandom();
      burst_left = 0;
      for (int i = 0; i < PhaseItems; i++) begin
        next_sample(mic);
        advance_time();
        send_sample(mic, time_now);
      end
      drain();
    end

    $display("%0d samples sent over %0d setting phases and four idle patterns", sent,
             NumPhases + 1);
    $display("%0d results checked, %0d beat peaks among them", results, peaks);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/alba_pkg.sv
hw/rtl/alba_ctrl.sv
hw/rtl/alba_dp.sv
hw/rtl/audio_level_beat_agc_top.sv
hw/rtl/alba_chk.sv
sim/audio_level_beat_agc_checker.sv
sim/tb_audio_level_beat_agc_top.sv
